### rtl/fbif_pkg.sv
// ============================================================================
// fbif_pkg: shared types and codes for the bucket issue filter
// Holds the request and decision codes and the distance width.
// ============================================================================
package fbif_pkg;

    localparam int DIST_BITS = 36;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    typedef enum logic [1:0] {
        REQ_LOAD_BOX  = 2'd0,
        REQ_SET_FAR   = 2'd1,
        REQ_CHECK     = 2'd2,
        REQ_UNUSED    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        DEC_ISSUE  = 2'd0,
        DEC_FORCED = 2'd1,
        DEC_SKIP   = 2'd2,
        DEC_DEFER  = 2'd3
    } t_dec;

endpackage

### rtl/fps_bucket_issue_filter.sv
// ============================================================================
// fps_bucket_issue_filter: bucket issue filter for farthest point sampling
// Holds per-bucket boxes, far points and deferred lists in memories and
// decides for each sample check whether to issue, skip or defer.
// ============================================================================
// Usage:
// A request beat is taken at a clock edge with i_start high and o_busy low.
// Load-box and set-far requests write the bucket table and give no result.
// A check request reads the bucket entry, registers the squared gaps and then
// the squared distances, passes a wait state, and then registers the decision
// with the first result beat. Beats follow one per cycle on o_valid. A skip or
// defer gives one beat; an issue or a forced issue gives the deferred indices
// in arrival order and then the sample index.
// The receiver cannot stall: each beat is shown for exactly one cycle.
// A check keeps o_busy high until its last beat is registered. The rate is set
// by the single read port of the bucket memories and the drain of the deferred
// list, one beat per cycle. After reset a clearing pass walks every bucket,
// setting the far distance to infinity and the counts and far index to zero;
// o_busy is high throughout it. i_cfg_we writes the merge limit; the user must
// write it only while no check is in flight, as the block does not enforce
// this. Unused request types and out-of-range buckets are dropped.
module fps_bucket_issue_filter #(
    parameter int NUM_BUCKETS = 256,
    parameter int MERGE_DEPTH = 8,
    parameter int COORD_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [3:0]            i_cfg_wdata,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [1:0]            i_req_type,
    input  logic [7:0]            i_bucket_id,
    input  logic signed [COORD_BITS-1:0] i_first_x,
    input  logic signed [COORD_BITS-1:0] i_first_y,
    input  logic signed [COORD_BITS-1:0] i_first_z,
    input  logic signed [COORD_BITS-1:0] i_second_x,
    input  logic signed [COORD_BITS-1:0] i_second_y,
    input  logic signed [COORD_BITS-1:0] i_second_z,
    input  logic [15:0]           i_point_index,
    input  logic [35:0]           i_far_sq_distance,
    input  logic                  i_first_pass,
    output logic                  o_valid,
    output logic [1:0]            o_decision,
    output logic [15:0]           o_reference_index,
    output logic [3:0]            o_deferred_count,
    output logic                  o_last_reference
);
    import fbif_pkg::*;

    localparam int BW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int LW  = (MERGE_DEPTH > 1) ? $clog2(MERGE_DEPTH) : 1;
    localparam int LD  = 1 << LW;         // list slots per bucket
    localparam int CB  = COORD_BITS;
    localparam int GB  = CB + 1;          // gap magnitude bits
    localparam int SB  = 2 * GB;          // squared gap bits
    localparam int XB  = 3 * CB;
    localparam logic [3:0] DEPTH4 = 4'(MERGE_DEPTH > 15 ? 15 : MERGE_DEPTH);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_GAP, S_SUM, S_DECIDE, S_DRAIN
    } t_state;

    // Bucket memories: one read port, one write port each.
    logic [XB-1:0]        m_box_min [NUM_BUCKETS];
    logic [XB-1:0]        m_box_max [NUM_BUCKETS];
    logic [XB-1:0]        m_far_xyz [NUM_BUCKETS];
    logic [15:0]          m_far_idx [NUM_BUCKETS];
    logic [DIST_BITS-1:0] m_far_dist[NUM_BUCKETS];
    logic [3:0]           m_count   [NUM_BUCKETS];
    logic [15:0]          m_list    [NUM_BUCKETS*LD];

    t_state               r_state;
    logic [BW:0]          r_clr;
    logic [3:0]           r_limit;
    logic [BW-1:0]        r_id;
    logic [XB-1:0]        r_p;
    logic [15:0]          r_pidx;
    logic                 r_fpass;

    // Read data registers.
    logic [XB-1:0]        r_rd_min, r_rd_max, r_rd_far;
    logic [DIST_BITS-1:0] r_rd_fdist;
    logic [3:0]           r_rd_cnt;
    logic [15:0]          r_rd_list;

    logic [SB-1:0]        r_gf [3];
    logic [SB-1:0]        r_gb [3];
    logic [SB+1:0]        r_dfar, r_dbox;
    t_dec                 r_dec;
    logic [3:0]           r_drain;

    logic                 r_valid, r_last;
    logic [1:0]           r_odec;
    logic [15:0]          r_oref;
    logic [3:0]           r_ocnt;

    // Memory write controls (combinational).
    logic                 w_cnt_we, w_list_we, w_wbox, w_wfar;
    logic [BW-1:0]        w_addr;
    logic [3:0]           w_cnt_d;
    logic [LW-1:0]        w_list_slot;
    logic [BW-1:0]        w_rd_addr;
    logic [LW-1:0]        w_rd_slot;

    logic                 w_acc, w_inrange;
    logic [3:0]           w_eff_limit;
    logic [DIST_BITS-1:0] w_dfar_s, w_dbox_s;

    assign w_acc     = i_start && (r_state == S_IDLE);
    assign w_inrange = (9'(i_bucket_id) < 9'(NUM_BUCKETS)) || (NUM_BUCKETS >= 256);
    assign w_eff_limit = (r_limit < DEPTH4) ? r_limit : DEPTH4;

    function automatic logic [SB-1:0] sq(input logic [GB-1:0] g);
        return SB'(g) * SB'(g);
    endfunction

    function automatic logic [GB-1:0] absd(input logic signed [CB-1:0] a,
                                           input logic signed [CB-1:0] b);
        logic signed [GB-1:0] d;
        d = GB'(a) - GB'(b);
        return d[GB-1] ? GB'(-d) : GB'(d);
    endfunction

    assign w_dfar_s = (r_dfar > (SB+2)'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(r_dfar);
    assign w_dbox_s = (r_dbox > (SB+2)'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(r_dbox);

    // Write port selection.
    always_comb begin
        w_cnt_we    = 1'b0;
        w_list_we   = 1'b0;
        w_wbox      = 1'b0;
        w_wfar      = 1'b0;
        w_addr      = r_id;
        w_cnt_d     = '0;
        w_list_slot = LW'(r_rd_cnt);
        if (r_state == S_CLEAR) begin
            w_addr   = r_clr[BW-1:0];
            w_cnt_we = 1'b1;
            w_wfar   = 1'b1;
        end else if (w_acc && w_inrange) begin
            w_addr = BW'(i_bucket_id);
            w_wbox = (i_req_type == REQ_LOAD_BOX);
            w_wfar = (i_req_type == REQ_SET_FAR);
        end else if (r_state == S_DECIDE) begin
            if (!r_fpass && (r_rd_fdist < w_dfar_s) && !(r_rd_fdist < w_dbox_s)
                && !(r_rd_cnt >= w_eff_limit)) begin
                w_cnt_we  = 1'b1;
                w_list_we = 1'b1;
                w_cnt_d   = r_rd_cnt + 4'd1;
            end else if (r_fpass || !(r_rd_fdist < w_dfar_s)
                         || (!(r_rd_fdist < w_dbox_s) && (r_rd_cnt >= w_eff_limit))) begin
                w_cnt_we = 1'b1;
            end
        end
    end

    // The drain reads one slot ahead so each beat finds its index registered.
    assign w_rd_addr = (r_state == S_IDLE) ? BW'(i_bucket_id) : r_id;
    assign w_rd_slot = (r_state == S_DRAIN)  ? LW'(r_drain + 4'd2) :
                       (r_state == S_DECIDE) ? LW'(1) : '0;

    always_ff @(posedge i_clk) begin
        if (w_wbox) begin
            m_box_min[w_addr] <= {i_first_z, i_first_y, i_first_x};
            m_box_max[w_addr] <= {i_second_z, i_second_y, i_second_x};
        end
        if (w_wfar) begin
            m_far_xyz[w_addr]  <= {i_first_z, i_first_y, i_first_x};
            m_far_idx[w_addr]  <= (r_state == S_CLEAR) ? 16'd0 : i_point_index;
            m_far_dist[w_addr] <= (r_state == S_CLEAR) ? DIST_MAX : i_far_sq_distance;
        end
        if (w_cnt_we) m_count[w_addr] <= w_cnt_d;
        if (w_list_we) m_list[{w_addr, w_list_slot}] <= r_pidx;
        r_rd_min   <= m_box_min[w_rd_addr];
        r_rd_max   <= m_box_max[w_rd_addr];
        r_rd_far   <= m_far_xyz[w_rd_addr];
        r_rd_fdist <= m_far_dist[w_rd_addr];
        r_rd_list  <= m_list[{w_rd_addr, w_rd_slot}];
        if (r_state == S_READ || r_state == S_IDLE) r_rd_cnt <= m_count[w_rd_addr];
    end

    // Pipeline datapath and request registers.
    always_ff @(posedge i_clk) begin
        logic signed [CB-1:0] p, mn, mx, f;
        for (int a = 0; a < 3; a++) begin
            p  = r_p[a*CB +: CB];
            mn = r_rd_min[a*CB +: CB];
            mx = r_rd_max[a*CB +: CB];
            f  = r_rd_far[a*CB +: CB];
            r_gf[a] <= sq(absd(f, p));
            r_gb[a] <= (p < mn) ? sq(absd(mn, p)) : (p > mx) ? sq(absd(p, mx)) : '0;
        end
        r_dfar <= (SB+2)'(r_gf[0]) + (SB+2)'(r_gf[1]) + (SB+2)'(r_gf[2]);
        r_dbox <= (SB+2)'(r_gb[0]) + (SB+2)'(r_gb[1]) + (SB+2)'(r_gb[2]);
        if (w_acc) begin
            r_id    <= BW'(i_bucket_id);
            r_p     <= {i_first_z, i_first_y, i_first_x};
            r_pidx  <= i_point_index;
            r_fpass <= i_first_pass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_limit <= 4'd8;
            r_valid <= 1'b0;
            r_drain <= '0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_wdata;
            r_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (BW+1)'(NUM_BUCKETS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (w_acc && w_inrange && i_req_type == REQ_CHECK) r_state <= S_READ;
                end
                S_READ:   r_state <= S_GAP;
                S_GAP:    r_state <= S_SUM;
                S_SUM:    r_state <= S_DECIDE;
                S_DECIDE: begin
                    r_valid <= 1'b1;
                    r_ocnt  <= r_rd_cnt;
                    r_drain <= '0;
                    if (r_fpass || !(r_rd_fdist < w_dfar_s) ||
                        (!(r_rd_fdist < w_dbox_s) && r_rd_cnt >= w_eff_limit)) begin
                        r_odec <= (r_fpass || !(r_rd_fdist < w_dfar_s)) ? DEC_ISSUE
                                                                        : DEC_FORCED;
                        if (r_rd_cnt == 4'd0) begin
                            r_oref  <= r_pidx;
                            r_last  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_oref  <= r_rd_list;
                            r_last  <= 1'b0;
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_odec  <= (r_rd_fdist < w_dbox_s) ? DEC_SKIP : DEC_DEFER;
                        r_oref  <= 16'd0;
                        r_last  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_DRAIN: begin
                    r_valid <= 1'b1;
                    r_drain <= r_drain + 4'd1;
                    if (r_drain + 4'd1 == r_ocnt) begin
                        r_oref  <= r_pidx;
                        r_last  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_oref <= r_rd_list;
                        r_last <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_decision        = r_odec;
    assign o_reference_index = r_oref;
    assign o_deferred_count  = r_ocnt;
    assign o_last_reference  = r_last;

    // A drain never outruns the stored count.
    a_drain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_drain < r_ocnt))
        else $error("drain index beyond deferred count");
    // Skip and defer beats are always the final beat of a request.
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_odec == DEC_SKIP || r_odec == DEC_DEFER)) |-> r_last)
        else $error("skip or defer not marked last");
    // No request is taken while result beats are still going out.
    a_no_accept_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |-> o_busy)
        else $error("accepted during drain");

endmodule
